// ===== sv/kmeans_2d_clustering_defines.svh =====
// assertion macros used by the top-level module
`ifndef KMEANS_2D_CLUSTERING_DEFINES_SVH
`define KMEANS_2D_CLUSTERING_DEFINES_SVH

// same-cycle implication
`define KM2D_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KM2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/km2d_pkg.sv =====
package km2d_pkg;

    localparam int COORD_W = 16;
    localparam int CFG_W = 14;
    localparam logic [CFG_W-1:0] ROUND_CAP = 14'd10000;

    localparam logic [1:0] FUNC_LOAD_PT = 2'd0;
    localparam logic [1:0] FUNC_LOAD_CTR = 2'd1;
    localparam logic [1:0] FUNC_RUN = 2'd2;

    localparam logic REG_CLUSTER_COUNT = 1'b0;
    localparam logic REG_ITER_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
    } t_in;

    typedef struct packed {
        logic [2:0] center_index;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [8:0] member_count;
        logic [CFG_W-1:0] rounds_used;
        logic last;
    } t_out;

    typedef struct packed {
        logic load_pt;
        logic load_ctr;
        logic run_init;
        logic rnd_init;
        logic pt_read;
        logic sq;
        logic cmp;
        logic acc;
        logic upd_init;
        logic next_j;
        logic div_start;
        logic upd_write;
        logic rnd_end;
        logic emit_init;
        logic emit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic pts_done;
        logic j_last;
        logic cnt_zero;
        logic div_done;
        logic keep_going;
    } t_sts;

endpackage

// ===== sv/kmeans_2d_clustering.sv =====
// load items (point or initial center) are taken in the idle state; busy stays low after them
// a run repeats rounds until no center moves or the round limit is reached; each round steps
// through the points with the shared squared-distance unit, then updates centers with the bit-serial divider
// after the last round the K results come out back to back, one strobe each
// the receiver cannot stall; synchronous active-low reset clears counts and centers and sets config to defaults
`include "kmeans_2d_clustering_defines.svh"

module kmeans_2d_clustering import km2d_pkg::*; #(
    parameter int MAX_POINTS = 256,
    parameter int MAX_CLUSTERS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in              i_in,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_valid,
    output t_out             o_res
);
    t_cmd cmd;
    t_sts sts;

    km2d_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_func(i_in.func),
        .i_sts(sts), .o_cmd(cmd), .busy(busy)
    );

    km2d_dp #(.MAX_POINTS(MAX_POINTS), .MAX_CLUSTERS(MAX_CLUSTERS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts), .i_in(i_in),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_res(o_res)
    );

    `KM2D_ASSERT_NEXT(a_run_goes_busy, i_clk, i_rst_n, start && !busy && i_in.func == FUNC_RUN, busy, "run transfer did not start work")
    `KM2D_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_valid && o_res.last, !o_valid, "result after last")
    `KM2D_ASSERT_NOW(a_valid_from_run, i_clk, i_rst_n, o_valid, $past(busy), "result without a run")
endmodule

// ===== sv/km2d_div.sv =====
module km2d_div import km2d_pkg::*; #(
    parameter int SW = 24,
    parameter int CW = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [SW-1:0] i_num,
    input  logic [CW-1:0]        i_den,
    output logic                 o_done,
    output logic signed [SW-1:0] o_quo
);
    localparam int NW = $clog2(SW + 1);

    logic [NW-1:0] r_cnt;
    logic [CW-1:0] r_rem;
    logic [SW-1:0] r_q;
    logic [CW-1:0] r_den;
    logic          r_neg;
    logic          r_done;
    logic [CW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_q[SW-1]};
    assign fits = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= NW'(SW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q <= i_num[SW-1] ? SW'(-i_num) : i_num;
            r_den <= i_den;
            r_neg <= i_num[SW-1];
        end else if (r_cnt != '0) begin
            r_rem <= fits ? CW'(trial - {1'b0, r_den}) : trial[CW-1:0];
            r_q <= {r_q[SW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

// ===== sv/km2d_dp.sv =====
module km2d_dp import km2d_pkg::*; #(
    parameter int MAX_POINTS = 256,
    parameter int MAX_CLUSTERS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  t_in              i_in,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_valid,
    output t_out             o_res
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int KW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int KCW = $clog2(MAX_CLUSTERS + 1);
    localparam int SW = COORD_W + AW;

    logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
    logic signed [COORD_W-1:0] mem_y [MAX_POINTS];

    logic [3:0]       r_cfg_k;
    logic [CFG_W-1:0] r_cfg_lim;
    logic [KW-1:0]    r_klast;
    logic [CFG_W-1:0] r_limit;
    logic [CFG_W-1:0] r_rounds;
    logic [PCW-1:0]   r_np;
    logic [KCW-1:0]   r_nc;
    logic [PCW-1:0]   r_i;
    logic [KW-1:0]    r_j;
    logic [KW-1:0]    r_best;
    logic [32:0]      r_bestd;
    logic             r_moved;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic [31:0]      r_sqx;
    logic [31:0]      r_sqy;
    logic signed [COORD_W-1:0] r_cx [MAX_CLUSTERS];
    logic signed [COORD_W-1:0] r_cy [MAX_CLUSTERS];
    logic signed [SW-1:0]      r_sx [MAX_CLUSTERS];
    logic signed [SW-1:0]      r_sy [MAX_CLUSTERS];
    logic [PCW-1:0]   r_cnt [MAX_CLUSTERS];
    logic             r_valid;
    t_out             r_res;

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [31:0] sqx;
    logic [31:0] sqy;
    logic [32:0] dsum;
    logic div_done;
    logic signed [SW-1:0] qx;
    logic signed [SW-1:0] qy;
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic [KW-1:0] klast_cfg;

    always_comb begin
        dx = (COORD_W + 1)'(r_px) - (COORD_W + 1)'(r_cx[r_j]);
        dy = (COORD_W + 1)'(r_py) - (COORD_W + 1)'(r_cy[r_j]);
        ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        sqx = ax * ax;
        sqy = ay * ay;
        dsum = {1'b0, r_sqx} + {1'b0, r_sqy};
        nx = qx[COORD_W-1:0];
        ny = qy[COORD_W-1:0];
        if (r_cfg_k == '0) begin
            klast_cfg = '0;
        end else if ({1'b0, r_cfg_k} > 5'(MAX_CLUSTERS)) begin
            klast_cfg = KW'(MAX_CLUSTERS - 1);
        end else begin
            klast_cfg = KW'(r_cfg_k - 4'd1);
        end
    end

    km2d_div #(.SW(SW), .CW(PCW)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_sx[r_j]), .i_den(r_cnt[r_j]), .o_done(div_done), .o_quo(qx)
    );

    km2d_div #(.SW(SW), .CW(PCW)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_sy[r_j]), .i_den(r_cnt[r_j]), .o_done(), .o_quo(qy)
    );

    // point store, point read and squared-distance registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pt && r_np < PCW'(MAX_POINTS)) begin
            mem_x[r_np[AW-1:0]] <= i_in.coord_x;
            mem_y[r_np[AW-1:0]] <= i_in.coord_y;
        end
        if (i_cmd.pt_read) begin
            r_px <= mem_x[r_i[AW-1:0]];
            r_py <= mem_y[r_i[AW-1:0]];
        end
        if (i_cmd.sq) begin
            r_sqx <= sqx;
            r_sqy <= sqy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_k <= 4'd3;
            r_cfg_lim <= ROUND_CAP;
            r_klast <= '0;
            r_limit <= '0;
            r_rounds <= '0;
            r_np <= '0;
            r_nc <= '0;
            r_i <= '0;
            r_j <= '0;
            r_best <= '0;
            r_bestd <= '0;
            r_moved <= 1'b0;
            r_valid <= 1'b0;
            for (int c = 0; c < MAX_CLUSTERS; c++) begin
                r_cx[c] <= '0;
                r_cy[c] <= '0;
                r_sx[c] <= '0;
                r_sy[c] <= '0;
                r_cnt[c] <= '0;
            end
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_CLUSTER_COUNT) begin
                    r_cfg_k <= i_cfg_data[3:0];
                end else begin
                    r_cfg_lim <= i_cfg_data;
                end
            end
            if (i_cmd.load_pt && r_np < PCW'(MAX_POINTS)) begin
                r_np <= r_np + 1'b1;
            end
            if (i_cmd.load_ctr && r_nc < KCW'(MAX_CLUSTERS)) begin
                r_cx[r_nc[KW-1:0]] <= i_in.coord_x;
                r_cy[r_nc[KW-1:0]] <= i_in.coord_y;
                r_nc <= r_nc + 1'b1;
            end
            if (i_cmd.run_init) begin
                r_klast <= klast_cfg;
                r_rounds <= '0;
                if (r_cfg_lim == '0) begin
                    r_limit <= CFG_W'(1);
                end else if (r_cfg_lim > ROUND_CAP) begin
                    r_limit <= ROUND_CAP;
                end else begin
                    r_limit <= r_cfg_lim;
                end
            end
            if (i_cmd.rnd_init) begin
                r_i <= '0;
                r_moved <= 1'b0;
                for (int c = 0; c < MAX_CLUSTERS; c++) begin
                    r_sx[c] <= '0;
                    r_sy[c] <= '0;
                    r_cnt[c] <= '0;
                end
            end
            if (i_cmd.pt_read || i_cmd.upd_init || i_cmd.emit_init) begin
                r_j <= '0;
            end
            if (i_cmd.cmp) begin
                if (r_j == '0 || dsum < r_bestd) begin
                    r_bestd <= dsum;
                    r_best <= r_j;
                end
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.acc) begin
                r_sx[r_best] <= r_sx[r_best] + SW'(r_px);
                r_sy[r_best] <= r_sy[r_best] + SW'(r_py);
                r_cnt[r_best] <= r_cnt[r_best] + 1'b1;
                r_i <= r_i + 1'b1;
            end
            if (i_cmd.next_j) begin
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.upd_write) begin
                if (nx != r_cx[r_j] || ny != r_cy[r_j]) begin
                    r_moved <= 1'b1;
                end
                r_cx[r_j] <= nx;
                r_cy[r_j] <= ny;
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.rnd_end) begin
                r_rounds <= r_rounds + 1'b1;
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
                r_res.center_index <= 3'(r_j);
                r_res.center_x <= r_cx[r_j];
                r_res.center_y <= r_cy[r_j];
                r_res.member_count <= 9'(r_cnt[r_j]);
                r_res.rounds_used <= r_rounds;
                r_res.last <= (r_j == r_klast);
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.finish) begin
                r_np <= '0;
                r_nc <= '0;
            end
        end
    end

    assign o_sts.pts_done = (r_i == r_np);
    assign o_sts.j_last = (r_j == r_klast);
    assign o_sts.cnt_zero = (r_cnt[r_j] == '0);
    assign o_sts.div_done = div_done;
    assign o_sts.keep_going = r_moved && (CFG_W'(r_rounds + 1'b1) < r_limit);
    assign o_valid = r_valid;
    assign o_res = r_res;
endmodule

// ===== sv/km2d_ctrl.sv =====
module km2d_ctrl import km2d_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_func,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       busy
);
    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_RND  = 11'b000_0000_0010,
        ST_PT   = 11'b000_0000_0100,
        ST_SQ   = 11'b000_0000_1000,
        ST_CMP  = 11'b000_0001_0000,
        ST_ACC  = 11'b000_0010_0000,
        ST_UCHK = 11'b000_0100_0000,
        ST_DIV  = 11'b000_1000_0000,
        ST_UWR  = 11'b001_0000_0000,
        ST_REND = 11'b010_0000_0000,
        ST_EMIT = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_func == FUNC_LOAD_PT) begin
                        o_cmd.load_pt = 1'b1;
                    end else if (i_func == FUNC_LOAD_CTR) begin
                        o_cmd.load_ctr = 1'b1;
                    end else if (i_func == FUNC_RUN) begin
                        o_cmd.run_init = 1'b1;
                        n_state = ST_RND;
                    end
                end
            end
            ST_RND: begin
                o_cmd.rnd_init = 1'b1;
                n_state = ST_PT;
            end
            ST_PT: begin
                if (i_sts.pts_done) begin
                    o_cmd.upd_init = 1'b1;
                    n_state = ST_UCHK;
                end else begin
                    o_cmd.pt_read = 1'b1;
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.sq = 1'b1;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = i_sts.j_last ? ST_ACC : ST_SQ;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = ST_PT;
            end
            ST_UCHK: begin
                if (!i_sts.cnt_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_DIV;
                end else if (i_sts.j_last) begin
                    n_state = ST_REND;
                end else begin
                    o_cmd.next_j = 1'b1;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_UWR;
                end
            end
            ST_UWR: begin
                o_cmd.upd_write = 1'b1;
                n_state = i_sts.j_last ? ST_REND : ST_UCHK;
            end
            ST_REND: begin
                o_cmd.rnd_end = 1'b1;
                if (i_sts.keep_going) begin
                    n_state = ST_RND;
                end else begin
                    o_cmd.emit_init = 1'b1;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.j_last) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);
endmodule

// ===== tb/kmeans_2d_clustering_checker.sv =====
`timescale 1ns / 1ps

module kmeans_2d_clustering_checker import km2d_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  t_in              i_in,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    input  t_out             i_res,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int NPTS = 256;
    localparam int NCTR = 8;

    int   pt_x [NPTS];
    int   pt_y [NPTS];
    int   ctr_x [NCTR];
    int   ctr_y [NCTR];
    int   pts_loaded;
    int   ctrs_loaded;
    int   k_reg;
    int   limit_reg;
    t_out center_q [$];

    function automatic longint sq_dist(int p, int c);
        longint dx;
        longint dy;
        dx = longint'(pt_x[p]) - longint'(ctr_x[c]);
        dy = longint'(pt_y[p]) - longint'(ctr_y[c]);
        return dx * dx + dy * dy;
    endfunction

    task automatic run_clusters();
        int     k;
        int     lim;
        int     rounds;
        int     best;
        int     nx;
        int     ny;
        bit     moved;
        longint d;
        longint bd;
        longint sx [NCTR];
        longint sy [NCTR];
        int     cnt [NCTR];
        t_out   r;
        k = (k_reg < 1) ? 1 : (k_reg > NCTR) ? NCTR : k_reg;
        lim = (limit_reg < 1) ? 1 : (limit_reg > int'(ROUND_CAP)) ? int'(ROUND_CAP) : limit_reg;
        rounds = 0;
        do begin
            moved = 0;
            for (int j = 0; j < NCTR; j++) begin
                sx[j] = 0;
                sy[j] = 0;
                cnt[j] = 0;
            end
            for (int i = 0; i < pts_loaded; i++) begin
                best = 0;
                bd = sq_dist(i, 0);
                for (int j = 1; j < k; j++) begin
                    d = sq_dist(i, j);
                    if (d < bd) begin
                        bd = d;
                        best = j;
                    end
                end
                cnt[best]++;
                sx[best] += pt_x[i];
                sy[best] += pt_y[i];
            end
            for (int j = 0; j < k; j++) begin
                if (cnt[j] != 0) begin
                    nx = int'(sx[j] / longint'(cnt[j]));
                    ny = int'(sy[j] / longint'(cnt[j]));
                    if (nx != ctr_x[j] || ny != ctr_y[j])
                        moved = 1;
                    ctr_x[j] = nx;
                    ctr_y[j] = ny;
                end
            end
            rounds++;
        end while (rounds < lim && moved);
        for (int j = 0; j < k; j++) begin
            r.center_index = j[2:0];
            r.center_x = ctr_x[j][15:0];
            r.center_y = ctr_y[j][15:0];
            r.member_count = cnt[j][8:0];
            r.rounds_used = rounds[CFG_W-1:0];
            r.last = (j == k - 1);
            center_q.push_back(r);
        end
        pts_loaded = 0;
        ctrs_loaded = 0;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending <= 0;
            for (int j = 0; j < NCTR; j++) begin
                ctr_x[j] = 0;
                ctr_y[j] = 0;
            end
            pts_loaded = 0;
            ctrs_loaded = 0;
            k_reg = 3;
            limit_reg = 10000;
            center_q.delete();
        end else begin
            if (i_valid) begin
                if (center_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, i_res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = center_q.pop_front();
                    if (want.center_index !== i_res.center_index
                            || want.center_x !== i_res.center_x
                            || want.center_y !== i_res.center_y
                            || want.member_count !== i_res.member_count
                            || want.rounds_used !== i_res.rounds_used
                            || want.last !== i_res.last) begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, i_res);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_CLUSTER_COUNT)
                    k_reg = int'(i_cfg_data[3:0]);
                else
                    limit_reg = int'(i_cfg_data);
            end
            if (i_start && !i_busy) begin
                case (i_in.func)
                    FUNC_LOAD_PT: begin
                        if (pts_loaded < NPTS) begin
                            pt_x[pts_loaded] = int'(i_in.coord_x);
                            pt_y[pts_loaded] = int'(i_in.coord_y);
                            pts_loaded++;
                        end
                    end
                    FUNC_LOAD_CTR: begin
                        if (ctrs_loaded < NCTR) begin
                            ctr_x[ctrs_loaded] = int'(i_in.coord_x);
                            ctr_y[ctrs_loaded] = int'(i_in.coord_y);
                            ctrs_loaded++;
                        end
                    end
                    FUNC_RUN: run_clusters();
                    default: ;
                endcase
            end
            o_pending <= center_q.size();
        end
    end

endmodule

// ===== tb/kmeans_2d_clustering_test.sv =====
`timescale 1ns / 1ps

module kmeans_2d_clustering_test;
    import km2d_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int IDLE_LIMIT = 25000000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_in              i_in = '0;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = REG_CLUSTER_COUNT;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             o_valid;
    t_out             o_res;
    int               fail_count;
    int               pending;
    int               n_items = 0;
    int               n_runs = 0;
    int               idle_cycles = 0;
    bit               steady = 0;

    always #2 i_clk = ~i_clk;

    kmeans_2d_clustering u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_res      (o_res)
    );

    kmeans_2d_clustering_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_in         (i_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (o_valid),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_cmd(input logic [1:0] f, input logic [15:0] x, input logic [15:0] y);
        if (!steady && $urandom_range(99) < 6) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        start = 1'b1;
        i_in.func = f;
        i_in.coord_x = x;
        i_in.coord_y = y;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (f != FUNC_NONE)
            n_items++;
        if (f == FUNC_RUN)
            n_runs++;
    endtask

    task automatic settle();
        start = 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [15:0] rand_coord(input int mode, input int base);
        if (mode == 0)
            return $urandom();
        return 16'(base + $urandom_range(0, 200) - 100);
    endfunction

    function automatic logic [CFG_W-1:0] pick_k();
        case ($urandom_range(9))
            0: return 0;
            1: return 15;
            2: return 8;
            3: return 1;
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_limit();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return 16383;
            3: return $urandom_range(2, 5);
            default: return 10000;
        endcase
    endfunction

    initial begin
        int nc;
        int np;
        int mode;
        int bases [8];
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // run with nothing loaded at reset settings
        push_cmd(FUNC_RUN, 16'h1234, 16'h5678);
        settle();
        write_reg(REG_CLUSTER_COUNT, 2);
        write_reg(REG_ITER_LIMIT, 10000);
        // extreme centers and points
        push_cmd(FUNC_LOAD_CTR, 16'h8000, 16'h8000);
        push_cmd(FUNC_LOAD_CTR, 16'h7fff, 16'h7fff);
        push_cmd(FUNC_LOAD_PT, 16'h8000, 16'h7fff);
        push_cmd(FUNC_LOAD_PT, 16'h7fff, 16'h8000);
        push_cmd(FUNC_LOAD_PT, 16'h8000, 16'h8000);
        push_cmd(FUNC_LOAD_PT, 16'h7fff, 16'h7fff);
        push_cmd(FUNC_NONE, 16'hffff, 16'hffff);
        push_cmd(FUNC_RUN, 16'h0, 16'h0);
        settle();
        // tie between identical centers, one cluster left empty
        write_reg(REG_CLUSTER_COUNT, 3);
        push_cmd(FUNC_LOAD_CTR, 16'd10, 16'd10);
        push_cmd(FUNC_LOAD_CTR, 16'd10, 16'd10);
        push_cmd(FUNC_LOAD_CTR, 16'hfff6, 16'hfff6);
        push_cmd(FUNC_LOAD_PT, 16'd0, 16'd0);
        push_cmd(FUNC_LOAD_PT, 16'd20, 16'd20);
        push_cmd(FUNC_LOAD_PT, 16'hfffd, 16'd1);
        push_cmd(FUNC_RUN, 16'h0, 16'h0);
        settle();
        // round limit reached with out-of-range settings
        write_reg(REG_CLUSTER_COUNT, 15);
        write_reg(REG_ITER_LIMIT, 0);
        push_cmd(FUNC_LOAD_PT, 16'd1000, 16'hfc18);
        push_cmd(FUNC_LOAD_PT, 16'hf000, 16'd3);
        push_cmd(FUNC_LOAD_PT, 16'd7, 16'd7);
        push_cmd(FUNC_RUN, 16'h0, 16'h0);
        settle();
        write_reg(REG_CLUSTER_COUNT, 0);
        write_reg(REG_ITER_LIMIT, 16383);
        push_cmd(FUNC_LOAD_PT, 16'hffff, 16'h0001);
        push_cmd(FUNC_RUN, 16'h0, 16'h0);

        while (n_items < 170) begin
            steady = (n_items > 60 && n_items < 110);
            if ($urandom_range(3) == 0) begin
                settle();
                write_reg(REG_CLUSTER_COUNT, pick_k());
                write_reg(REG_ITER_LIMIT, pick_limit());
            end
            mode = $urandom_range(2) == 0 ? 0 : 1;
            foreach (bases[j])
                bases[j] = $urandom_range(0, 60000) - 30000;
            nc = $urandom_range(0, 9);
            for (int j = 0; j < nc; j++)
                push_cmd(FUNC_LOAD_CTR, rand_coord(mode, bases[j % 8]),
                         rand_coord(mode, bases[(j + 3) % 8]));
            np = $urandom_range(0, 20);
            for (int i = 0; i < np; i++) begin
                if ($urandom_range(19) == 0)
                    push_cmd(FUNC_NONE, $urandom(), $urandom());
                push_cmd(FUNC_LOAD_PT, rand_coord(mode, bases[i % 8]),
                         rand_coord(mode, bases[(i + 3) % 8]));
            end
            push_cmd(FUNC_RUN, $urandom(), $urandom());
        end

        settle();
        repeat (20) @(negedge i_clk);

        $display("covered %0d transfers with %0d clustering runs", n_items, n_runs);
        $display("cluster counts 0..15, round limits 0..16383, center store overflow");
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
